>>> hdl/ids_pkg.sv
// Shared constants, types and ring-address helper for the indexed deque store.
package ids_pkg;

    // Store geometry.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W1     = PTR_W + 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths on the streams.
    localparam int ACTION_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 4;
    localparam int RVAL_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int ICOUNT_W   = 5;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_BITS    = ACTION_W + VALUE_W + POS_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = RVAL_W + STATUS_W + ICOUNT_W + 1;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_AT    = 3'd4,
        ACT_READ_FRONT = 3'd5,
        ACT_READ_BACK  = 3'd6,
        ACT_CLEAR      = 3'd7
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2,
        STS_FULL  = 2'd3
    } sts_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;        // a request transfer is taken this cycle
        logic load_direct; // result is known now, load the output register
        logic load_ram;    // load the output register from the store read data
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             rd_ok; // offered request is a read that will succeed
        logic [CNT_W-1:0] count; // current element count
    } dp_sts_t;

    // (base + offset) mod DEPTH, with both operands below DEPTH.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] offset);
        logic [PTR_W1-1:0] sum;
        sum = PTR_W1'(base) + PTR_W1'(offset);
        if (sum >= PTR_W1'(DEPTH)) begin
            sum = sum - PTR_W1'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

>>> hdl/indexed_deque_store_core.sv
// Top level of the indexed deque store: a bounded double-ended queue in a ring store.
//
// Requests arrive on the s_ stream, one request per transfer, and each request
// produces exactly one result transfer on the m_ stream, in request order.
// A request pushes at the front or back, pops at the front or back, reads at a
// position counted from the front, reads the front or back, or clears the queue.
// Every result carries the word read (zero unless a read succeeds), a status,
// the element count after the request and an empty flag.
//
// For pushes, pops, clear and every request that ends in an error status, the
// result is registered at the edge that takes the request, and the next request
// can be taken in the following cycle when the receiver is ready. A successful
// read passes through the registered read port of the store memory and the
// ST_READ state, and the request port is held off while in ST_READ.
//
// A synchronous active-low reset empties the queue and drops any pending result;
// the stored words are not cleared and need no clearing pass. When the receiver
// stalls, the result waits in the output register and one further request can
// still be taken only if the output register drains in that same cycle.
module indexed_deque_store_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata from bit 0: action[2:0], value[34:3], position[38:35], zero pad[39].
    input  logic [ids_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata from bit 0: read_value[31:0], status[33:32], item_count[38:34],
    // is_empty[39].
    output logic [ids_pkg::OUT_W-1:0] m_tdata
);
    import ids_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // The controller decides when requests and results move.
    ids_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_sts   (dp_sts),
        .dp_cmd   (dp_cmd)
    );

    // The datapath holds the pointers, the ring store and the result register.
    ids_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .dp_cmd  (dp_cmd),
        .dp_sts  (dp_sts)
    );

    // The element count never goes beyond the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_sts.count <= CNT_W'(DEPTH))
        else $error("element count exceeds store depth");

    // A successful read holds off the request port while the read is in flight.
    a_read_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && dp_sts.rd_ok) |=> !s_tready)
        else $error("request taken while a read is in flight");

    // Any request that is not a successful read has its result valid next cycle.
    a_direct_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !dp_sts.rd_ok) |=> m_tvalid)
        else $error("single-cycle request produced no result");

    // A result reported as empty always carries a zero count.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39] == (m_tdata[38:34] == '0)))
        else $error("empty flag disagrees with item count");

endmodule

>>> hdl/ids_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/ids_ctrl.sv
// Controller state machine: request acceptance, read wait and result valid.
module ids_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  ids_pkg::dp_sts_t dp_sts,
    output ids_pkg::dp_cmd_t dp_cmd
);
    import ids_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The output register is free when empty or drained in this cycle.
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next         = state_reg;
        s_tready           = 1'b0;
        dp_cmd.exec        = 1'b0;
        dp_cmd.load_direct = 1'b0;
        dp_cmd.load_ram    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = out_free;
                dp_cmd.exec = s_tvalid && out_free;
                if (dp_cmd.exec) begin
                    if (dp_sts.rd_ok) begin
                        state_next = ST_READ;
                    end else begin
                        dp_cmd.load_direct = 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    dp_cmd.load_ram = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (dp_cmd.load_direct || dp_cmd.load_ram) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> hdl/ids_dpath.sv
// Datapath: head pointer, element count, ring store and result register.
module ids_dpath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ids_pkg::IN_W-1:0]  s_tdata,
    output logic [ids_pkg::OUT_W-1:0] m_tdata,
    input  ids_pkg::dp_cmd_t          dp_cmd,
    output ids_pkg::dp_sts_t          dp_sts
);
    import ids_pkg::*;

    act_t                  action;
    logic [VALUE_W-1:0]    value;
    logic [POS_W-1:0]      position;

    logic [PTR_W-1:0]      head_reg, head_next, head_upd, head_dec;
    logic [CNT_W-1:0]      count_reg, count_next, count_upd;
    logic                  is_empty_now, is_full_now;
    sts_t                  sts;
    logic                  rd_ok;
    logic                  wr_sel;
    logic [PTR_W-1:0]      wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [RVAL_W-1:0]     rval_reg;
    sts_t                  status_reg;
    logic [ICOUNT_W-1:0]   icount_reg;
    logic                  empty_reg;

    assign action   = act_t'(s_tdata[ACTION_W-1:0]);
    assign value    = s_tdata[ACTION_W +: VALUE_W];
    assign position = s_tdata[ACTION_W + VALUE_W +: POS_W];

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == CNT_W'(DEPTH));
    assign head_dec     = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);

    always_comb begin
        sts       = STS_OK;
        head_upd  = head_reg;
        count_upd = count_reg;
        wr_sel    = 1'b0;
        wr_addr   = head_reg;
        rd_addr   = head_reg;
        rd_ok     = 1'b0;
        case (action)
            ACT_PUSH_FRONT: begin
                if (is_full_now) begin
                    sts = STS_FULL;
                end else begin
                    wr_sel    = 1'b1;
                    wr_addr   = head_dec;
                    head_upd  = head_dec;
                    count_upd = count_reg + CNT_W'(1);
                end
            end
            ACT_PUSH_BACK: begin
                if (is_full_now) begin
                    sts = STS_FULL;
                end else begin
                    wr_sel    = 1'b1;
                    wr_addr   = ring_add(head_reg, PTR_W'(count_reg));
                    count_upd = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (is_empty_now) begin
                    sts = STS_EMPTY;
                end else begin
                    head_upd  = ring_add(head_reg, PTR_W'(1));
                    count_upd = count_reg - CNT_W'(1);
                end
            end
            ACT_POP_BACK: begin
                if (is_empty_now) begin
                    sts = STS_EMPTY;
                end else begin
                    count_upd = count_reg - CNT_W'(1);
                end
            end
            ACT_READ_AT: begin
                if (is_empty_now) begin
                    sts = STS_EMPTY;
                end else if (CMP_W'(position) >= CMP_W'(count_reg)) begin
                    sts = STS_RANGE;
                end else begin
                    rd_ok   = 1'b1;
                    rd_addr = ring_add(head_reg, PTR_W'(position));
                end
            end
            ACT_READ_FRONT: begin
                if (is_empty_now) begin
                    sts = STS_EMPTY;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            ACT_READ_BACK: begin
                if (is_empty_now) begin
                    sts = STS_EMPTY;
                end else begin
                    rd_ok   = 1'b1;
                    rd_addr = ring_add(head_reg, PTR_W'(count_reg - CNT_W'(1)));
                end
            end
            ACT_CLEAR: begin
                head_upd  = '0;
                count_upd = '0;
            end
            default: begin
            end
        endcase
    end

    assign head_next  = dp_cmd.exec ? head_upd : head_reg;
    assign count_next = dp_cmd.exec ? count_upd : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    ids_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (dp_cmd.exec && wr_sel),
        .wr_addr (wr_addr),
        .wr_data (DATA_WIDTH'(value)),
        .rd_en   (dp_cmd.exec && rd_ok),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A read leaves head and count alone, so the current count is the result count.
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_direct) begin
            rval_reg   <= '0;
            status_reg <= sts;
            icount_reg <= ICOUNT_W'(count_upd);
            empty_reg  <= (count_upd == '0);
        end else if (dp_cmd.load_ram) begin
            rval_reg   <= RVAL_W'(rd_data);
            status_reg <= STS_OK;
            icount_reg <= ICOUNT_W'(count_reg);
            empty_reg  <= 1'b0;
        end
    end

    assign m_tdata = OUT_W'({empty_reg, icount_reg, status_reg, rval_reg});

    assign dp_sts.rd_ok = rd_ok;
    assign dp_sts.count = count_reg;

endmodule
